// File: sv/btm_pkg.sv
// Shared request, status and link codes for the breakpoint table manager.
`timescale 1ns / 1ps
package btm_pkg;

  localparam logic [2:0] REQ_ADD   = 3'd0;
  localparam logic [2:0] REQ_DEL   = 3'd1;
  localparam logic [2:0] REQ_DALL  = 3'd2;
  localparam logic [2:0] REQ_QRY   = 3'd3;
  localparam logic [2:0] REQ_LOC   = 3'd4;
  localparam logic [2:0] REQ_SIZE  = 3'd5;
  localparam logic [2:0] REQ_INIT  = 3'd6;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_CLASS = 3'd1;
  localparam logic [2:0] ST_BAD_INST  = 3'd2;
  localparam logic [2:0] ST_BAD_POS   = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_NOT_FOUND = 3'd5;

  localparam logic [1:0] CFG_CODE_COUNT   = 2'd0;
  localparam logic [1:0] CFG_INST_LIMIT   = 2'd1;
  localparam logic [1:0] CFG_BREAK_OP     = 2'd2;
  localparam logic [1:0] CFG_ACT_BREAK_OP = 2'd3;

  localparam logic [7:0] NO_LINK = 8'hFF;

  typedef struct packed {
    logic [7:0]  patch_opcode;
    logic [15:0] patch_pos;
    logic [5:0]  patch_code_index;
    logic        patch_valid;
    logic [15:0] found_instance;
    logic        found;
    logic [31:0] result_id;
    logic [2:0]  status;
  } result_t;

endpackage

// File: sv/breakpoint_table_manager_top.sv
// Breakpoint table manager: chained breakpoint slots, id allocation, code patch requests.
`timescale 1ns / 1ps
// Usage:
//  - Requests enter on s_* (tuser = request kind, tdata = code_index, code_pos,
//    instance_req, target_id, size_value from bit 0 up). One request at a time;
//    s_tready is high only while the sequencer is idle.
//  - Results leave on m_*; every request ends with one result flagged by m_tlast.
//    Delete all gives one result per chained entry before its final one.
//  - Config writes on cfg_*: index 0 code object count, 1 instance limit,
//    2 break opcode, 3 active break opcode. Always ready; write while idle.
//  - Operation: the sequencer walks one table slot per cycle. Add scans from
//    slot 0 for the lowest free slot, query and delete walk the chain (up to
//    TABLE_ENTRIES slots), delete also scans all slots once and then, unless the
//    entry was the list head, walks again to unlink after its result is taken.
//    Delete all reads each chained entry, then hands off its result.
//  - A result waits in the output register while m_tready is low; the sequencer
//    holds there and resumes when it is taken.
//  - Reset: table empty, id counter 1, all code objects not loaded, config zero.
module breakpoint_table_manager_top #(
  parameter int TABLE_ENTRIES = 32,
  parameter int CODE_OBJECTS  = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // code_index[15:0], code_pos[31:16], instance_req[47:32], target_id[79:48],
  // size_value[96:80], zero pad
  input  logic [103:0] s_tdata,
  // req_type[2:0]
  input  logic [2:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // status[2:0], result_id[34:3], found[35], found_instance[51:36],
  // patch_valid[52], patch_code_index[58:53], patch_pos[74:59],
  // patch_opcode[82:75], zero pad
  output logic [87:0]  m_tdata,
  output logic         m_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int JW = IW + 1;
  localparam int CW = (CODE_OBJECTS > 1) ? $clog2(CODE_OBJECTS) : 1;
  localparam logic [JW-1:0] N_ENT = JW'(TABLE_ENTRIES);
  localparam logic [7:0]    N_ENT8 = 8'(TABLE_ENTRIES);

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_ADDCHK, S_FREE, S_DEL_WALK, S_DEL_SAME, S_UNLINK,
    S_DA_RD, S_DA_EMIT, S_FIND, S_OUT
  } state_t;

  state_t state, after_out;

  // request latch
  logic [2:0]  req;
  logic [15:0] ci, pos, inst;
  logic [31:0] tid;
  logic [16:0] sz;

  // config
  logic [6:0]  code_count;
  logic [15:0] inst_limit;
  logic [7:0]  break_op, act_break_op;

  // table
  logic [31:0] entry_id   [TABLE_ENTRIES];
  logic [5:0]  entry_code [TABLE_ENTRIES];
  logic [15:0] entry_pos  [TABLE_ENTRIES];
  logic [15:0] entry_inst [TABLE_ENTRIES];
  logic [7:0]  entry_next [TABLE_ENTRIES];
  logic [7:0]  list_head;
  logic [31:0] id_counter, new_id;

  // walk control
  logic [7:0]    cur;
  logic [JW-1:0] steps, j;
  logic [IW-1:0] d;
  logic [1:0]    same_cnt;

  // code size memory with per-object valid bits
  logic [16:0]      size_mem [CODE_OBJECTS];
  logic             size_vld [CODE_OBJECTS];
  logic [CW-1:0]    sz_addr;
  logic [16:0]      sz_q;
  logic             sz_v;
  logic             loaded;

  btm_pkg::result_t res;
  logic             res_last;

  logic [IW-1:0] cur_i, j_i;
  logic [7:0]    cur_link, first_slot;
  logic [31:0]   id_inc;
  logic          ci_obj_ok, walk_end;
  logic [5:0]    d_code, cur_code;

  assign cur_i      = cur[IW-1:0];
  assign j_i        = j[IW-1:0];
  assign cur_link   = (entry_next[cur_i] < N_ENT8) ? entry_next[cur_i] : btm_pkg::NO_LINK;
  assign first_slot = (list_head < N_ENT8) ? list_head : btm_pkg::NO_LINK;
  assign id_inc     = (id_counter == 32'hFFFF_FFFF) ? 32'd1 : id_counter + 32'd1;
  assign ci_obj_ok  = ({16'd0, ci} < 32'(CODE_OBJECTS));
  assign walk_end   = (cur == btm_pkg::NO_LINK) || (steps == N_ENT);
  assign d_code     = entry_code[d];
  assign cur_code   = entry_code[cur_i];
  assign loaded     = sz_v && (sz_q != 17'd0);

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign m_tvalid  = (state == S_OUT);
  assign m_tdata   = {5'd0, res};
  assign m_tlast   = res_last;

  always_comb begin
    unique case (state)
      S_DEL_SAME:         sz_addr = d_code[CW-1:0];
      S_DA_RD, S_DA_EMIT: sz_addr = cur_code[CW-1:0];
      default:            sz_addr = ci[CW-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    sz_q <= size_mem[sz_addr];
    if (state == S_DISP && req == btm_pkg::REQ_SIZE && ci_obj_ok) begin
      size_mem[ci[CW-1:0]] <= sz;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      after_out  <= S_IDLE;
      code_count <= '0;
      inst_limit <= '0;
      break_op   <= '0;
      act_break_op <= '0;
      list_head  <= btm_pkg::NO_LINK;
      id_counter <= 32'd1;
      sz_v       <= 1'b0;
      res_last   <= 1'b0;
      for (int k = 0; k < TABLE_ENTRIES; k++) begin
        entry_id[k]   <= '0;
        entry_next[k] <= '0;
      end
      for (int k = 0; k < CODE_OBJECTS; k++) begin
        size_vld[k] <= 1'b0;
      end
    end else begin
      sz_v <= size_vld[sz_addr];

      if (cfg_valid) begin
        unique case (cfg_index)
          btm_pkg::CFG_CODE_COUNT:   code_count   <= cfg_data[6:0];
          btm_pkg::CFG_INST_LIMIT:   inst_limit   <= cfg_data;
          btm_pkg::CFG_BREAK_OP:     break_op     <= cfg_data[7:0];
          btm_pkg::CFG_ACT_BREAK_OP: act_break_op <= cfg_data[7:0];
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            req   <= s_tuser;
            ci    <= s_tdata[15:0];
            pos   <= s_tdata[31:16];
            inst  <= s_tdata[47:32];
            tid   <= s_tdata[79:48];
            sz    <= s_tdata[96:80];
            state <= S_DISP;
          end
        end

        S_DISP: begin
          res       <= '0;
          res_last  <= 1'b1;
          after_out <= S_IDLE;
          cur       <= first_slot;
          steps     <= '0;
          unique case (req)
            btm_pkg::REQ_ADD: begin
              if (ci >= {9'd0, code_count} || !ci_obj_ok) begin
                res.status <= btm_pkg::ST_BAD_CLASS;
                state      <= S_OUT;
              end else if (inst >= inst_limit) begin
                res.status <= btm_pkg::ST_BAD_INST;
                state      <= S_OUT;
              end else begin
                state <= S_ADDCHK;
              end
            end
            btm_pkg::REQ_DEL:  state <= S_DEL_WALK;
            btm_pkg::REQ_DALL: state <= S_DA_RD;
            btm_pkg::REQ_QRY, btm_pkg::REQ_LOC: state <= S_FIND;
            btm_pkg::REQ_SIZE: begin
              if (!ci_obj_ok) begin
                res.status <= btm_pkg::ST_BAD_CLASS;
              end else begin
                size_vld[ci[CW-1:0]] <= 1'b1;
              end
              state <= S_OUT;
            end
            btm_pkg::REQ_INIT: begin
              for (int k = 0; k < TABLE_ENTRIES; k++) begin
                entry_id[k]   <= '0;
                entry_next[k] <= '0;
              end
              list_head  <= btm_pkg::NO_LINK;
              id_counter <= id_inc;
              state      <= S_OUT;
            end
            default: state <= S_OUT;
          endcase
        end

        S_ADDCHK: begin
          if (loaded && {1'b0, pos} >= sz_q) begin
            res.status <= btm_pkg::ST_BAD_POS;
            state      <= S_OUT;
          end else begin
            new_id     <= id_counter;
            id_counter <= id_inc;
            j          <= '0;
            state      <= S_FREE;
          end
        end

        S_FREE: begin
          if (j == N_ENT) begin
            res.status <= btm_pkg::ST_FULL;
            state      <= S_OUT;
          end else if (entry_id[j_i] == 32'd0) begin
            entry_id[j_i]   <= new_id;
            entry_code[j_i] <= ci[5:0];
            entry_pos[j_i]  <= pos;
            entry_inst[j_i] <= inst;
            entry_next[j_i] <= list_head;
            list_head       <= 8'(j_i);
            res.result_id   <= new_id;
            if (loaded) begin
              res.patch_valid      <= 1'b1;
              res.patch_code_index <= ci[5:0];
              res.patch_pos        <= pos;
              res.patch_opcode     <= act_break_op;
            end
            state <= S_OUT;
          end else begin
            j <= j + 1'b1;
          end
        end

        S_DEL_WALK: begin
          if (walk_end) begin
            res.status <= btm_pkg::ST_NOT_FOUND;
            state      <= S_OUT;
          end else if (tid != 32'd0 && entry_id[cur_i] == tid) begin
            d        <= cur_i;
            j        <= '0;
            same_cnt <= '0;
            state    <= S_DEL_SAME;
          end else begin
            cur   <= cur_link;
            steps <= steps + 1'b1;
          end
        end

        S_DEL_SAME: begin
          if (j == N_ENT) begin
            res.result_id <= tid;
            if (same_cnt == 2'd1 && {2'd0, d_code} < 8'(CODE_OBJECTS) && loaded) begin
              res.patch_valid      <= 1'b1;
              res.patch_code_index <= d_code;
              res.patch_pos        <= entry_pos[d];
              res.patch_opcode     <= break_op;
            end
            entry_id[d] <= '0;
            if (8'(d) == list_head) begin
              list_head     <= entry_next[d];
              entry_next[d] <= btm_pkg::NO_LINK;
              after_out     <= S_IDLE;
            end else begin
              cur       <= first_slot;
              steps     <= '0;
              after_out <= S_UNLINK;
            end
            state <= S_OUT;
          end else begin
            if (entry_id[j_i] != 32'd0 && entry_code[j_i] == d_code &&
                entry_pos[j_i] == entry_pos[d] && same_cnt != 2'd2) begin
              same_cnt <= same_cnt + 2'd1;
            end
            j <= j + 1'b1;
          end
        end

        S_UNLINK: begin
          if (walk_end) begin
            state <= S_IDLE;
          end else if (entry_next[cur_i] == 8'(d)) begin
            entry_next[cur_i] <= entry_next[d];
            state             <= S_IDLE;
          end else begin
            cur   <= cur_link;
            steps <= steps + 1'b1;
          end
        end

        S_DA_RD: begin
          res <= '0;
          if (walk_end) begin
            res_last  <= 1'b1;
            after_out <= S_IDLE;
            for (int k = 0; k < TABLE_ENTRIES; k++) begin
              entry_id[k]   <= '0;
              entry_next[k] <= '0;
            end
            list_head  <= btm_pkg::NO_LINK;
            id_counter <= id_inc;
            state      <= S_OUT;
          end else begin
            state <= S_DA_EMIT;
          end
        end

        S_DA_EMIT: begin
          res_last      <= 1'b0;
          after_out     <= S_DA_RD;
          res.result_id <= entry_id[cur_i];
          if ({2'd0, cur_code} < 8'(CODE_OBJECTS) && loaded) begin
            res.patch_valid      <= 1'b1;
            res.patch_code_index <= cur_code;
            res.patch_pos        <= entry_pos[cur_i];
            res.patch_opcode     <= break_op;
          end
          cur   <= cur_link;
          steps <= steps + 1'b1;
          state <= S_OUT;
        end

        S_FIND: begin
          if (walk_end) begin
            state <= S_OUT;
          end else if (entry_id[cur_i] != 32'd0 && {10'd0, cur_code} == ci &&
                       entry_pos[cur_i] == pos &&
                       (req != btm_pkg::REQ_QRY || entry_inst[cur_i] == inst)) begin
            res.result_id      <= entry_id[cur_i];
            res.found          <= 1'b1;
            res.found_instance <= entry_inst[cur_i];
            state              <= S_OUT;
          end else begin
            cur   <= cur_link;
            steps <= steps + 1'b1;
          end
        end

        S_OUT: begin
          if (m_tready) begin
            state <= after_out;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (rst) m_tvalid |-> !s_tready)
    else $error("request accepted while a result is pending");
  a_head_ok: assert property (@(posedge clk) disable iff (rst)
    (list_head == btm_pkg::NO_LINK) || (list_head < N_ENT8))
    else $error("list head out of range");
  a_id_nonzero: assert property (@(posedge clk) disable iff (rst) id_counter != 32'd0)
    else $error("id counter reached zero");
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> (state == S_IDLE || state == S_UNLINK))
    else $error("sequencer busy after final result");
`endif

endmodule
